>>> design/smm_pkg.sv
// Shared constants, types and helper functions of the small matrix multiply block.
// No dependencies; every other file of the block refers to this package by scoped names.
package smm_pkg;

	localparam int MAX_DIM   = 8;
	localparam int ELEM_BITS = 16;

	localparam int VALUE_W   = 16;
	localparam int SUM_W     = 35;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int OP_W      = 2;
	localparam int POS_W     = 3;

	localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CNT_W      = $clog2(MAX_DIM + 1);
	localparam int MEM_DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int PROD_W     = 2 * ELEM_BITS;
	localparam int EXT_W      = (PROD_W > SUM_W) ? PROD_W : SUM_W;
	localparam int ELEM_EXT_W = (ELEM_BITS > VALUE_W) ? ELEM_BITS : VALUE_W;

	localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
	localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

	localparam logic [CFG_W-1:0] CFG_DIM_RESET = 4'd8;

	// One multiply-accumulate step on its way through the datapath.
	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
		logic              first;
		logic              last_k;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic              last;
	} issue_t;

	// Store write for a load item.
	typedef struct packed {
		logic                 we_a;
		logic                 we_b;
		logic [ADDR_W-1:0]    addr;
		logic [ELEM_BITS-1:0] data;
	} wr_t;

	// Size register as used: zero counts as one, anything above MAX_DIM as MAX_DIM.
	function automatic logic [CNT_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [CNT_W-1:0] d;
		if (v == '0) begin
			d = CNT_W'(1);
		end else if (int'(v) > MAX_DIM) begin
			d = CNT_W'(MAX_DIM);
		end else begin
			d = v[CNT_W-1:0];
		end
		return d;
	endfunction

	// Low ELEM_BITS bits of the input value, zero filled when the element is wider.
	function automatic logic [ELEM_BITS-1:0] elem_of(input logic [VALUE_W-1:0] v);
		logic [ELEM_EXT_W-1:0] t;
		t = ELEM_EXT_W'(v);
		return t[ELEM_BITS-1:0];
	endfunction

	// Product sign extended or wrapped to the sum width.
	function automatic logic [SUM_W-1:0] sum_of_prod(input logic signed [PROD_W-1:0] p);
		logic signed [EXT_W-1:0] t;
		t = EXT_W'(p);
		return t[SUM_W-1:0];
	endfunction

endpackage

>>> design/smm_item_if.sv
// Input channel of the small matrix multiply block: valid/ready plus one item.
// Depends on smm_pkg for field widths.
interface smm_item_if;
	logic                                valid;
	logic                                ready;
	logic [smm_pkg::OP_W-1:0]            op;
	logic [smm_pkg::POS_W-1:0]           row;
	logic [smm_pkg::POS_W-1:0]           col;
	logic signed [smm_pkg::VALUE_W-1:0]  value;

	modport source(output valid, output op, output row, output col, output value, input ready);
	modport sink(input valid, input op, input row, input col, input value, output ready);
endinterface

>>> design/smm_result_if.sv
// Result channel of the small matrix multiply block: valid/ready plus one C element.
// Depends on smm_pkg for field widths.
interface smm_result_if;
	logic                              valid;
	logic                              ready;
	logic [smm_pkg::POS_W-1:0]         out_row;
	logic [smm_pkg::POS_W-1:0]         out_col;
	logic signed [smm_pkg::SUM_W-1:0]  sum;
	logic                              last;

	modport source(output valid, output out_row, output out_col, output sum, output last,
		input ready);
	modport sink(input valid, input out_row, input out_col, input sum, input last,
		output ready);
endinterface

>>> design/small_matrix_multiply.sv
// Top level of the small matrix multiply block: controller plus datapath.
// Depends on smm_pkg, smm_item_if, smm_result_if, smm_ctrl and smm_datapath.
//
// item   - input channel (valid/ready). op selects load A, load B or compute; row and col
//          place a loaded element, value is its signed content. A load outside the set
//          sizes is dropped; op 3 does nothing.
// result - output channel (valid/ready). A compute streams every C element in row-major
//          order: out_row/out_col, the exact sum of products, last on the final one.
// cfg_we / cfg_index / cfg_data - size registers rows_a (0), inner_size (1), cols_b (2);
//          write them only while the block is idle.
// Timing: a load is registered and written to its store in the cycle after its transfer. A
//   compute issues one multiply-accumulate per cycle while no result waits untaken (one
//   multiplier, one read port per store) and holds item.ready low until the last step has
//   read the stores. Each step passes the issue register, the store read, the product
//   register and the accumulator; a C element goes to the output register with its last step.
// Reset: sizes return to 8 and all control clears; store contents stay undefined until loaded.
// Stall: while a result waits untaken in the output register, the MAC pipeline and the
//   sequencer hold, and so does item.ready until the last step has read the stores.
module small_matrix_multiply (
	input  logic                           clk,
	input  logic                           arst_n,
	smm_item_if.sink                       item,
	smm_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [smm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smm_pkg::CFG_W-1:0]      cfg_data
);

	smm_pkg::issue_t issue;
	smm_pkg::wr_t    wr;
	logic            advance;

	// Sequencer and size registers.
	smm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.issue     (issue),
		.wr        (wr)
	);

	// Stores, multiply-accumulate pipeline and output register.
	smm_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue),
		.wr      (wr),
		.advance (advance),
		.result  (result)
	);

endmodule

>>> design/smm_ctrl.sv
// Controller: size registers, load decode and the row/column/inner-index sequencer.
// Depends on smm_pkg and smm_item_if; drives smm_datapath through issue_t and wr_t.
module smm_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	smm_item_if.sink                       item,
	input  logic                           cfg_we,
	input  logic [smm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smm_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           advance,
	output smm_pkg::issue_t                issue,
	output smm_pkg::wr_t                   wr
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t                        state_q;
	logic [smm_pkg::CFG_W-1:0]     rows_a_q;
	logic [smm_pkg::CFG_W-1:0]     inner_q;
	logic [smm_pkg::CFG_W-1:0]     cols_b_q;
	logic [smm_pkg::IDX_W-1:0]     r_q;
	logic [smm_pkg::IDX_W-1:0]     c_q;
	logic [smm_pkg::IDX_W-1:0]     k_q;
	smm_pkg::issue_t               issue_q;
	smm_pkg::wr_t                  wr_q;

	logic [smm_pkg::CNT_W-1:0]     nr;
	logic [smm_pkg::CNT_W-1:0]     nk;
	logic [smm_pkg::CNT_W-1:0]     nc;
	logic                          accept;
	logic                          a_ok;
	logic                          b_ok;
	logic                          k_end;
	logic                          c_end;
	logic                          r_end;
	logic [smm_pkg::ADDR_W-1:0]    wr_addr;

	always_comb begin
		nr      = smm_pkg::eff_dim(rows_a_q);
		nk      = smm_pkg::eff_dim(inner_q);
		nc      = smm_pkg::eff_dim(cols_b_q);
		accept  = item.valid && item.ready;
		a_ok    = (item.row < nr) && (item.col < nk);
		b_ok    = (item.row < nk) && (item.col < nc);
		k_end   = (smm_pkg::CNT_W'(k_q) == nk - smm_pkg::CNT_W'(1));
		c_end   = (smm_pkg::CNT_W'(c_q) == nc - smm_pkg::CNT_W'(1));
		r_end   = (smm_pkg::CNT_W'(r_q) == nr - smm_pkg::CNT_W'(1));
		wr_addr = smm_pkg::ADDR_W'(int'(item.row) * smm_pkg::MAX_DIM + int'(item.col));
	end

	// Hold off new items until the last step of a compute has read the stores.
	assign item.ready = (state_q == ST_IDLE) && !issue_q.valid;
	assign issue      = issue_q;
	assign wr         = wr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rows_a_q <= smm_pkg::CFG_DIM_RESET;
			inner_q  <= smm_pkg::CFG_DIM_RESET;
			cols_b_q <= smm_pkg::CFG_DIM_RESET;
			r_q      <= '0;
			c_q      <= '0;
			k_q      <= '0;
			issue_q  <= '0;
			wr_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					smm_pkg::CFG_ROWS_A: rows_a_q <= cfg_data;
					smm_pkg::CFG_INNER:  inner_q  <= cfg_data;
					smm_pkg::CFG_COLS_B: cols_b_q <= cfg_data;
					default: ;
				endcase
			end

			// Store writes never wait on the result side.
			wr_q.we_a <= accept && (item.op == smm_pkg::OP_LOAD_A) && a_ok;
			wr_q.we_b <= accept && (item.op == smm_pkg::OP_LOAD_B) && b_ok;
			wr_q.addr <= wr_addr;
			wr_q.data <= smm_pkg::elem_of(item.value);

			unique case (state_q)
				ST_IDLE: begin
					if (advance) begin
						issue_q.valid <= 1'b0;
					end
					if (accept && (item.op == smm_pkg::OP_COMPUTE)) begin
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (advance) begin
						issue_q.valid  <= 1'b1;
						issue_q.addr_a <= smm_pkg::ADDR_W'(int'(r_q) * smm_pkg::MAX_DIM
							+ int'(k_q));
						issue_q.addr_b <= smm_pkg::ADDR_W'(int'(k_q) * smm_pkg::MAX_DIM
							+ int'(c_q));
						issue_q.first  <= (k_q == '0);
						issue_q.last_k <= k_end;
						issue_q.row    <= smm_pkg::POS_W'(r_q);
						issue_q.col    <= smm_pkg::POS_W'(c_q);
						issue_q.last   <= r_end && c_end;
						if (!k_end) begin
							k_q <= k_q + 1'b1;
						end else begin
							k_q <= '0;
							if (!c_end) begin
								c_q <= c_q + 1'b1;
							end else begin
								c_q <= '0;
								r_q <= r_q + 1'b1;
								if (r_end) begin
									state_q <= ST_IDLE;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> design/smm_datapath.sv
// Datapath: the A and B stores, a registered multiplier, the accumulator and the result register.
// Depends on smm_pkg and smm_result_if; commanded by smm_ctrl.
module smm_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  smm_pkg::issue_t  issue,
	input  smm_pkg::wr_t     wr,
	output logic             advance,
	smm_result_if.source     result
);

	logic [smm_pkg::ELEM_BITS-1:0]        mem_a [smm_pkg::MEM_DEPTH];
	logic [smm_pkg::ELEM_BITS-1:0]        mem_b [smm_pkg::MEM_DEPTH];

	logic signed [smm_pkg::ELEM_BITS-1:0] a_s1;
	logic signed [smm_pkg::ELEM_BITS-1:0] b_s1;
	smm_pkg::issue_t                      tag_s1;
	logic                                 valid_s1;

	logic signed [smm_pkg::PROD_W-1:0]    prod_s2;
	smm_pkg::issue_t                      tag_s2;
	logic                                 valid_s2;

	logic [smm_pkg::SUM_W-1:0]            acc_q;
	logic [smm_pkg::SUM_W-1:0]            prod_ext;
	logic [smm_pkg::SUM_W-1:0]            acc_next;

	logic                                 out_valid_q;
	logic [smm_pkg::POS_W-1:0]            out_row_q;
	logic [smm_pkg::POS_W-1:0]            out_col_q;
	logic [smm_pkg::SUM_W-1:0]            sum_q;
	logic                                 last_q;

	logic                                 finish;

	// The whole MAC pipeline freezes while a result waits in the output register.
	assign advance = !out_valid_q || result.ready;

	always_comb begin
		prod_ext = smm_pkg::sum_of_prod(prod_s2);
		acc_next = tag_s2.first ? prod_ext : acc_q + prod_ext;
		finish   = advance && valid_s2 && tag_s2.last_k;
	end

	always_ff @(posedge clk) begin
		if (wr.we_a) begin
			mem_a[wr.addr] <= wr.data;
		end
		if (wr.we_b) begin
			mem_b[wr.addr] <= wr.data;
		end
		if (advance) begin
			a_s1    <= mem_a[issue.addr_a];
			b_s1    <= mem_b[issue.addr_b];
			tag_s1  <= issue;
			prod_s2 <= a_s1 * b_s1;
			tag_s2  <= tag_s1;
			if (valid_s2) begin
				acc_q <= acc_next;
			end
		end
		if (finish) begin
			out_row_q <= tag_s2.row;
			out_col_q <= tag_s2.col;
			sum_q     <= acc_next;
			last_q    <= tag_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_s1 <= issue.valid;
				valid_s2 <= valid_s1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid   = out_valid_q;
	assign result.out_row = out_row_q;
	assign result.out_col = out_col_q;
	assign result.sum     = sum_q;
	assign result.last    = last_q;

endmodule

>>> test/smm_checker.sv
// Scoreboard for the small matrix multiply block: watches both channels and the size port.
// Keeps its own copy of the sizes and both stores, predicts every C element and compares.
// Depends on smm_pkg, smm_item_if and smm_result_if.
module smm_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	smm_item_if                            item,
	smm_result_if                          result,
	input  logic                           cfg_we,
	input  logic [smm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [smm_pkg::CFG_W-1:0]      cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             items_seen,
	output int                             elems_seen,
	output int                             dim_rows,
	output int                             dim_inner,
	output int                             dim_cols
);
	timeunit 1ns;
	timeprecision 1ps;

	import smm_pkg::*;

	typedef struct {
		logic [POS_W-1:0]        row;
		logic [POS_W-1:0]        col;
		logic signed [SUM_W-1:0] sum;
		logic                    last;
	} c_elem_t;

	c_elem_t c_elems_due[$];

	logic signed [ELEM_BITS-1:0] a_elems[MEM_DEPTH];
	logic signed [ELEM_BITS-1:0] b_elems[MEM_DEPTH];
	logic [CFG_W-1:0] rows_reg, inner_reg, cols_reg;

	// Zero counts as one, anything past the array size as the array size.
	function automatic int used_dim(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	assign dim_rows  = used_dim(rows_reg);
	assign dim_inner = used_dim(inner_reg);
	assign dim_cols  = used_dim(cols_reg);

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		fail_count++;
		if (fail_count <= 40)
			$display("%0t mismatch: %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Queue every C element of the current sizes in row-major order.
	task automatic predict_product();
		c_elem_t e;
		longint  acc;
		for (int r = 0; r < dim_rows; r++) begin
			for (int c = 0; c < dim_cols; c++) begin
				acc = 0;
				for (int k = 0; k < dim_inner; k++) begin
					acc += longint'(a_elems[r * MAX_DIM + k]) * longint'(b_elems[k * MAX_DIM + c]);
				end
				e.row  = r[POS_W-1:0];
				e.col  = c[POS_W-1:0];
				e.sum  = acc[SUM_W-1:0];
				e.last = (r == dim_rows - 1) && (c == dim_cols - 1);
				c_elems_due.push_back(e);
			end
		end
	endtask

	task automatic take_item();
		int r, c;
		r = int'(item.row);
		c = int'(item.col);
		items_seen++;
		case (item.op)
			OP_LOAD_A: begin
				if (r < dim_rows && c < dim_inner)
					a_elems[r * MAX_DIM + c] = item.value;
			end
			OP_LOAD_B: begin
				if (r < dim_inner && c < dim_cols)
					b_elems[r * MAX_DIM + c] = item.value;
			end
			OP_COMPUTE: begin
				predict_product();
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_element();
		c_elem_t due;
		elems_seen++;
		if (c_elems_due.size() == 0) begin
			flag_mismatch("result element with nothing due, sum", longint'(result.sum), 0);
			return;
		end
		due = c_elems_due.pop_front();
		if (result.out_row !== due.row)
			flag_mismatch("out_row", longint'(result.out_row), longint'(due.row));
		if (result.out_col !== due.col)
			flag_mismatch("out_col", longint'(result.out_col), longint'(due.col));
		if (result.sum !== due.sum)
			flag_mismatch("sum", longint'(result.sum), longint'(due.sum));
		if (result.last !== due.last)
			flag_mismatch("last", longint'(result.last), longint'(due.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg   = CFG_DIM_RESET;
			inner_reg  = CFG_DIM_RESET;
			cols_reg   = CFG_DIM_RESET;
			c_elems_due.delete();
			pending    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROWS_A: rows_reg  = cfg_data;
					CFG_INNER:  inner_reg = cfg_data;
					CFG_COLS_B: cols_reg  = cfg_data;
					default: begin
					end
				endcase
			end
			if (result.valid && result.ready)
				check_element();
			if (item.valid && item.ready)
				take_item();
			pending = c_elems_due.size();
		end
	end

endmodule

>>> test/tb_top.sv
// Top of the small matrix multiply testbench: clock, reset, stimulus and the verdict.
// Depends on smm_pkg, both channel interfaces, the block and smm_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import smm_pkg::*;

	// Codes the block has no use for: an op that does nothing, an index with no register.
	localparam logic [OP_W-1:0]      OP_NONE  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

	localparam int SETTLE_CYCLES  = 16;    // past the longest first-result latency
	localparam int TAIL_CYCLES    = 32;
	localparam int HOLD_CYCLES    = 300;   // long output stall, well past the MAC pipeline depth
	localparam int WATCHDOG_LIMIT = 3000;  // cycles without any transfer

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	smm_item_if   item_ch();
	smm_result_if result_ch();

	int fail_count, pending, items_seen, elems_seen;
	int dim_rows, dim_inner, dim_cols;
	int settings_run;

	logic calm;        // high: no idling on either side
	logic hold_armed;  // high: stall the output once, for a long stretch

	// Store entries that have been loaded; a compute only reads loaded entries.
	bit a_loaded[MEM_DEPTH];
	bit b_loaded[MEM_DEPTH];

	small_matrix_multiply dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	smm_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.items_seen (items_seen),
		.elems_seen (elems_seen),
		.dim_rows   (dim_rows),
		.dim_inner  (dim_inner),
		.dim_cols   (dim_cols)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Output side. Decide ready at every falling edge: short random stalls, or once a
	// long hold-off that starts as soon as a result waits. The hold-off backs up the MAC
	// pipeline, so a compute stays in progress and the input channel stalls too.
	initial begin : receiver
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done  = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else if (hold_armed && !hold_done && result_ch.valid) begin
				hold_done  = 1;
				stall_left = HOLD_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 3);
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// Stop a hung run: count cycles in which neither channel moves a transfer.
	initial begin : watchdog
		int still_cycles;
		still_cycles = 0;
		while (still_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				still_cycles = 0;
			else
				still_cycles++;
		end
		$display("timeout: no transfer for %0d cycles, %0d results still due",
			WATCHDOG_LIMIT, pending);
		$display("RESULT: ERROR");
		$finish;
	end

	// Four cases in ten: the extremes of the element range, zero or minus one; otherwise anything.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return VALUE_W'($urandom);
		endcase
	endfunction

	// Offer one item, hold it until its transfer, then return at the next falling edge.
	// Record which store entries the load fills at the sizes now in force.
	task automatic offer_item(input logic [OP_W-1:0] op, input int r, input int c,
		input logic signed [VALUE_W-1:0] v);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op    <= op;
		item_ch.row   <= r[POS_W-1:0];
		item_ch.col   <= c[POS_W-1:0];
		item_ch.value <= v;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
		if (op == OP_LOAD_A && r < dim_rows && c < dim_inner)
			a_loaded[r * MAX_DIM + c] = 1;
		if (op == OP_LOAD_B && r < dim_inner && c < dim_cols)
			b_loaded[r * MAX_DIM + c] = 1;
	endtask

	// Fill every entry the product will read that was never loaded, then compute.
	task automatic offer_compute();
		for (int r = 0; r < dim_rows; r++)
			for (int k = 0; k < dim_inner; k++)
				if (!a_loaded[r * MAX_DIM + k])
					offer_item(OP_LOAD_A, r, k, pick_value());
		for (int k = 0; k < dim_inner; k++)
			for (int c = 0; c < dim_cols; c++)
				if (!b_loaded[k * MAX_DIM + c])
					offer_item(OP_LOAD_B, k, c, pick_value());
		offer_item(OP_COMPUTE, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
	endtask

	// Drop valid and pause until every expected element has arrived, then let the
	// pipeline settle so a trailing load has landed before anything else changes.
	task automatic wait_drained(input int tail);
		item_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	// Write the three size registers on consecutive cycles; call only while idle.
	task automatic set_sizes(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
		input logic [CFG_W-1:0] c);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROWS_A;
		cfg_data  <= r;
		@(negedge clk);
		cfg_index <= CFG_INNER;
		cfg_data  <= k;
		@(negedge clk);
		cfg_index <= CFG_COLS_B;
		cfg_data  <= c;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
		settings_run++;
	endtask

	// One size setting: mostly in-range loads with random content, some loads at any
	// position (many fall outside the sizes and get dropped), the odd unused op, and
	// computes. Always close with a compute so the setting yields results.
	task automatic run_phase(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
		input logic [CFG_W-1:0] c, input int count);
		int sel;
		wait_drained(SETTLE_CYCLES);
		set_sizes(r, k, c);
		repeat (count) begin
			sel = $urandom_range(0, 19);
			if (sel < 7)
				offer_item(OP_LOAD_A, $urandom_range(0, dim_rows - 1),
					$urandom_range(0, dim_inner - 1), pick_value());
			else if (sel < 14)
				offer_item(OP_LOAD_B, $urandom_range(0, dim_inner - 1),
					$urandom_range(0, dim_cols - 1), pick_value());
			else if (sel < 16)
				offer_item(sel[0] ? OP_LOAD_B : OP_LOAD_A, $urandom_range(0, 7),
					$urandom_range(0, 7), pick_value());
			else if (sel < 17)
				offer_item(OP_NONE, $urandom_range(0, 7), $urandom_range(0, 7), pick_value());
			else
				offer_compute();
		end
		offer_compute();
	endtask

	initial begin : stimulus
		// Drive every input to a known value from time zero, with reset held low at first.
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = CFG_ROWS_A;
		cfg_data        = CFG_DIM_RESET;
		item_ch.valid   = 1'b0;
		item_ch.op      = OP_LOAD_A;
		item_ch.row     = '0;
		item_ch.col     = '0;
		item_ch.value   = '0;
		result_ch.ready = 1'b0;
		calm            = 1'b0;
		hold_armed      = 1'b0;
		settings_run    = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, 1x1x1 with zero sizes standing for one: extreme products, loads past
		// the sizes, the unused op and the unused register index.
		set_sizes(4'd0, 4'd0, 4'd0);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_NONE;
		cfg_data  <= 4'hf;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
		offer_item(OP_LOAD_A, 0, 0, 16'sh8000);
		offer_item(OP_LOAD_B, 0, 0, 16'sh8000);
		offer_item(OP_COMPUTE, 0, 0, 16'sh0000);
		offer_item(OP_LOAD_A, 0, 0, 16'sh7fff);
		offer_item(OP_COMPUTE, 7, 7, 16'shffff);
		offer_item(OP_LOAD_B, 0, 0, 16'sh7fff);
		offer_item(OP_COMPUTE, 0, 0, 16'sh0000);
		offer_item(OP_LOAD_A, 7, 7, 16'sh5a5a);
		offer_item(OP_LOAD_B, 0, 7, 16'sha5a5);
		offer_item(OP_NONE, 7, 7, 16'shffff);
		offer_item(OP_COMPUTE, 0, 0, 16'sh0000);

		// Directed, 1x8x1: the largest sum, eight products of the most negative element.
		wait_drained(SETTLE_CYCLES);
		set_sizes(4'd1, 4'd8, 4'd1);
		for (int k = 0; k < MAX_DIM; k++)
			offer_item(OP_LOAD_A, 0, k, 16'sh8000);
		for (int k = 0; k < MAX_DIM; k++)
			offer_item(OP_LOAD_B, k, 0, 16'sh8000);
		offer_item(OP_COMPUTE, 0, 0, 16'sh0000);

		// Random settings, from small shapes to full size and clamped values.
		run_phase(4'd2, 4'd3, 4'd2, 10);
		run_phase(4'd15, 4'd1, 4'd3, 10);
		run_phase(4'd3, 4'd9, 4'd2, 10);
		hold_armed <= 1'b1;
		run_phase(4'd8, 4'd8, 4'd8, 12);
		run_phase(4'd0, 4'd5, 4'd8, 10);
		run_phase(4'd4, 4'd4, 4'd4, 10);
		// Last part at full rate on both sides.
		calm <= 1'b1;
		run_phase(4'd9, 4'd15, 4'd12, 11);

		wait_drained(TAIL_CYCLES);
		$display("covered %0d item transfers and %0d result elements over %0d size settings,",
			items_seen, elems_seen, settings_run);
		$display("with random stalls on both sides and one long output hold-off");
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches, %0d results never arrived", fail_count, pending);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> small_matrix_multiply.f
design/smm_pkg.sv
design/smm_item_if.sv
design/smm_result_if.sv
design/smm_ctrl.sv
design/smm_datapath.sv
design/small_matrix_multiply.sv
test/smm_checker.sv
test/tb_top.sv
